// ===== rtl/bcse_pkg.sv =====
// Shared types and constants for the bounded card stack engine.
package bcse_pkg;

  localparam int OP_W   = 3;
  localparam int RANK_W = 4;
  localparam int SUIT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_FIND   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_FIND
  } state_e;

  // Broadcast from the controller to every cell of the row
  typedef struct packed {
    logic              push_en;
    logic              shift_en;
    logic [RANK_W-1:0] push_rank;
    logic [SUIT_W-1:0] push_suit;
    logic [RANK_W-1:0] find_rank;
  } cell_ctrl_t;

endpackage

// ===== rtl/bcse_cell.sv =====
// One stack cell: holds a card, loads a pushed card or takes its upper neighbor.
module bcse_cell import bcse_pkg::*; #(
  parameter int INDEX = 0,
  parameter int CW    = 6
) (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [CW-1:0]     count_i,
  input  logic [CW-1:0]     pos_i,
  input  logic [RANK_W-1:0] next_rank_i,
  input  logic [SUIT_W-1:0] next_suit_i,
  output logic [RANK_W-1:0] rank_o,
  output logic [SUIT_W-1:0] suit_o,
  output logic              match_o
);

  localparam logic [CW-1:0] IDX = CW'(INDEX);

  logic [RANK_W-1:0] rank_q, rank_d;
  logic [SUIT_W-1:0] suit_q, suit_d;
  logic              at_top;
  logic              in_shift;

  assign at_top   = (IDX == count_i);
  // Move down only the valid entries above the removed one
  assign in_shift = (IDX >= pos_i) && (({1'b0, IDX} + 1'b1) < {1'b0, count_i});

  always_comb begin
    rank_d = rank_q;
    suit_d = suit_q;
    if (ctrl_i.push_en && at_top) begin
      rank_d = ctrl_i.push_rank;
      suit_d = ctrl_i.push_suit;
    end else if (ctrl_i.shift_en && in_shift) begin
      rank_d = next_rank_i;
      suit_d = next_suit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q <= rank_d;
    suit_q <= suit_d;
  end

  assign rank_o  = rank_q;
  assign suit_o  = suit_q;
  assign match_o = (rank_q == ctrl_i.find_rank) && (IDX < count_i);

endmodule

// ===== rtl/bcse_find_tree.sv =====
// Registered priority tree: lowest set match bit and its index.
module bcse_find_tree #(
  parameter int DEPTH = 52,
  parameter int IW    = 6
) (
  input  logic             clk_i,
  input  logic [DEPTH-1:0] match_i,
  output logic             found_o,
  output logic [IW-1:0]    index_o
);

  localparam int LVL   = (DEPTH > 1) ? $clog2(DEPTH) : 0;
  localparam int LEAVES = 1 << LVL;
  localparam int NODES  = 2 * LEAVES - 1;

  logic          found_q [NODES];
  logic [IW-1:0] idx_q   [NODES];

  // Leaves sample the match row; padding leaves never match
  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < DEPTH) begin : g_real
      always_ff @(posedge clk_i) begin
        found_q[LEAVES-1+i] <= match_i[i];
        idx_q[LEAVES-1+i]   <= IW'(i);
      end
    end else begin : g_pad
      always_ff @(posedge clk_i) begin
        found_q[LEAVES-1+i] <= 1'b0;
        idx_q[LEAVES-1+i]   <= '0;
      end
    end
  end

  // Each node prefers its left (lower index) child
  for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
    always_ff @(posedge clk_i) begin
      found_q[k] <= found_q[2*k+1] | found_q[2*k+2];
      idx_q[k]   <= found_q[2*k+1] ? idx_q[2*k+1] : idx_q[2*k+2];
    end
  end

  assign found_o = found_q[0];
  assign index_o = idx_q[0];

endmodule

// ===== rtl/bounded_card_stack_engine_core.sv =====
// Bounded card stack engine: a row of DEPTH cells holding cards bottom to top.
// Each transfer on the slave stream carries one operation (push, pop, remove at
// a position, find a rank, clear) and yields exactly one transfer on the master
// stream with the success flag, the removed card, the found index and the new
// entry count. Push, pop, remove and clear update the count and the cells in the
// cycle of the transfer, so they sustain one item per clock while the master
// stream takes the results. Find registers the searched rank, runs the cells'
// match row through a registered priority tree of LVL = ceil(log2(DEPTH))
// levels and holds off the input until its result is in the output register.
// A finished result waits in the output register and holds off the input until
// its transfer; the next item can be accepted in the same cycle as that transfer.
module bounded_card_stack_engine_core import bcse_pkg::*; #(
  parameter int DEPTH = 52
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [2:0] operation, [6:3] card_rank, [8:7] card_suit, then position; zero pad
  input  logic [((OP_W+RANK_W+SUIT_W+$clog2(DEPTH+1)+7)/8)*8-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] ok, [4:1] out_rank, [6:5] out_suit, then found_index, entry_count; pad
  output logic [((1+RANK_W+SUIT_W+2*$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL   = (DEPTH > 1) ? $clog2(DEPTH) : 0;
  localparam int LAT   = LVL + 1;
  localparam int WCW   = $clog2(LAT + 1);
  localparam int OUT_W = 1 + RANK_W + SUIT_W + 2 * CW;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  // Unpack the input transfer
  logic [OP_W-1:0]   in_op;
  logic [RANK_W-1:0] in_rank;
  logic [SUIT_W-1:0] in_suit;
  logic [CW-1:0]     in_pos;

  assign in_op   = s_axis_tdata[OP_W-1:0];
  assign in_rank = s_axis_tdata[OP_W+RANK_W-1:OP_W];
  assign in_suit = s_axis_tdata[OP_W+RANK_W+SUIT_W-1:OP_W+RANK_W];
  assign in_pos  = s_axis_tdata[OP_W+RANK_W+SUIT_W+CW-1:OP_W+RANK_W+SUIT_W];

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [RANK_W-1:0] find_rank_q, find_rank_d;
  logic [WCW-1:0]    wait_q, wait_d;

  logic              out_valid_q, out_valid_d;
  logic              out_ok_q, out_ok_d;
  logic [RANK_W-1:0] out_rank_q, out_rank_d;
  logic [SUIT_W-1:0] out_suit_q, out_suit_d;
  logic [CW-1:0]     out_fidx_q, out_fidx_d;
  logic [CW-1:0]     out_cnt_q, out_cnt_d;

  logic              accept;
  logic              push_ok, pop_ok, rem_ok, rem_mid;
  logic [CW-1:0]     rd_sel;
  logic [RANK_W-1:0] rd_rank;
  logic [SUIT_W-1:0] rd_suit;
  cell_ctrl_t        ctrl;

  logic [RANK_W-1:0] cell_rank [DEPTH];
  logic [SUIT_W-1:0] cell_suit [DEPTH];
  logic [DEPTH-1:0]  match;
  logic              tree_found;
  logic [IW-1:0]     tree_idx;

  // -------------------------------------------------------------------------
  // Cell row: each cell takes its upper neighbor on a remove
  // -------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [RANK_W-1:0] nxt_rank;
    logic [SUIT_W-1:0] nxt_suit;
    if (i + 1 < DEPTH) begin : g_mid
      assign nxt_rank = cell_rank[i+1];
      assign nxt_suit = cell_suit[i+1];
    end else begin : g_top
      assign nxt_rank = '0;
      assign nxt_suit = '0;
    end
    bcse_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .pos_i       (in_pos),
      .next_rank_i (nxt_rank),
      .next_suit_i (nxt_suit),
      .rank_o      (cell_rank[i]),
      .suit_o      (cell_suit[i]),
      .match_o     (match[i])
    );
  end

  bcse_find_tree #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_find_tree (
    .clk_i   (clk_i),
    .match_i (match),
    .found_o (tree_found),
    .index_o (tree_idx)
  );

  // -------------------------------------------------------------------------
  // Operation checks and removed-card read
  // -------------------------------------------------------------------------
  assign push_ok = (count_q < CW'(DEPTH));
  assign pop_ok  = (count_q != '0);
  assign rem_ok  = pop_ok && (in_pos <= count_q);
  assign rem_mid = (in_pos < count_q);

  // Pop and remove at the count read the top; otherwise read at the position
  assign rd_sel = ((in_op == OP_POP) || !rem_mid) ? (count_q - 1'b1) : in_pos;

  always_comb begin
    rd_rank = '0;
    rd_suit = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (rd_sel == CW'(i)) begin
        rd_rank = rd_rank | cell_rank[i];
        rd_suit = rd_suit | cell_suit[i];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_op == OP_FIND)) begin
          state_d = ST_FIND;
        end
      end
      ST_FIND: begin
        if (wait_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // Outputs of the controller: handshake, cell control, count, result
  // -------------------------------------------------------------------------
  // Take a new item only when idle and the output register is free or leaving
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ctrl.push_en   = 1'b0;
    ctrl.shift_en  = 1'b0;
    ctrl.push_rank = in_rank;
    ctrl.push_suit = in_suit;
    ctrl.find_rank = find_rank_q;
    count_d        = count_q;
    find_rank_d    = find_rank_q;
    wait_d         = wait_q;
    out_valid_d    = out_valid_q && !m_axis_tready;
    out_ok_d       = out_ok_q;
    out_rank_d     = out_rank_q;
    out_suit_d     = out_suit_q;
    out_fidx_d     = out_fidx_q;
    out_cnt_d      = out_cnt_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          out_ok_d    = 1'b0;
          out_rank_d  = '0;
          out_suit_d  = '0;
          out_fidx_d  = '0;
          case (in_op)
            OP_PUSH: begin
              if (push_ok) begin
                ctrl.push_en = 1'b1;
                count_d      = count_q + 1'b1;
                out_ok_d     = 1'b1;
              end
            end
            OP_POP: begin
              if (pop_ok) begin
                count_d    = count_q - 1'b1;
                out_ok_d   = 1'b1;
                out_rank_d = rd_rank;
                out_suit_d = rd_suit;
              end
            end
            OP_REMOVE: begin
              if (rem_ok) begin
                ctrl.shift_en = rem_mid;
                count_d       = count_q - 1'b1;
                out_ok_d      = 1'b1;
                out_rank_d    = rd_rank;
                out_suit_d    = rd_suit;
              end
            end
            OP_FIND: begin
              // Hold the result back until the tree has settled
              out_valid_d = 1'b0;
              find_rank_d = in_rank;
              wait_d      = WCW'(LAT);
            end
            OP_CLEAR: begin
              count_d  = '0;
              out_ok_d = 1'b1;
            end
            default: ;
          endcase
          out_cnt_d = count_d;
        end
      end
      ST_FIND: begin
        if (wait_q == '0) begin
          out_valid_d = 1'b1;
          out_ok_d    = tree_found;
          out_rank_d  = '0;
          out_suit_d  = '0;
          out_fidx_d  = tree_found ? CW'(tree_idx) : '0;
          out_cnt_d   = count_q;
        end else begin
          wait_d = wait_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // -------------------------------------------------------------------------
  // Registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    find_rank_q <= find_rank_d;
    out_ok_q    <= out_ok_d;
    out_rank_q  <= out_rank_d;
    out_suit_q  <= out_suit_d;
    out_fidx_q  <= out_fidx_d;
    out_cnt_q   <= out_cnt_d;
  end

  // Pack the result transfer
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TW'({out_cnt_q, out_fidx_q, out_suit_q, out_rank_q, out_ok_q});

endmodule

// ===== tb/tb_bounded_card_stack_engine_core.sv =====
// Self-checking testbench for the bounded card stack engine core.
`timescale 1ns / 100ps

module tb_bounded_card_stack_engine_core;
  import bcse_pkg::*;

  localparam int DEPTH = 52;
  localparam int POS_W = $clog2(DEPTH + 1);
  localparam int IN_W  = ((OP_W + RANK_W + SUIT_W + POS_W + 7) / 8) * 8;
  localparam int OUT_W = ((1 + RANK_W + SUIT_W + 2 * POS_W + 7) / 8) * 8;

  // Codes past clear that the block must ignore
  localparam logic [OP_W-1:0] OP_BAD_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_BAD_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_BAD_HI  = 3'd7;

  localparam int RAND_BLOCKS   = 9;
  localparam int BLOCK_ITEMS   = 42;
  localparam int HOLD_CYCLES   = 200;
  localparam int DRAIN_CYCLES  = 24;

  // Result fields from the lowest bit up: ok, rank, suit, found index, count
  typedef struct packed {
    logic [POS_W-1:0]  entry_count;
    logic [POS_W-1:0]  found_index;
    logic [SUIT_W-1:0] out_suit;
    logic [RANK_W-1:0] out_rank;
    logic              ok;
  } card_result_t;

  localparam int RES_W = $bits(card_result_t);

  // Tracks the card stack and the results still owed by the block
  class card_stack_tracker;
    logic [RANK_W-1:0] ranks [DEPTH];
    logic [SUIT_W-1:0] suits [DEPTH];
    int                held;
    int                errors;
    card_result_t      due_results[$];

    function new();
      held   = 0;
      errors = 0;
    endfunction

    // Apply one accepted operation and queue the result it must produce
    function void apply_op(logic [OP_W-1:0] op, logic [RANK_W-1:0] rank,
                           logic [SUIT_W-1:0] suit, logic [POS_W-1:0] pos);
      card_result_t r;
      int i;
      r = '0;
      case (op)
        OP_PUSH: begin
          if (held < DEPTH) begin
            ranks[held] = rank;
            suits[held] = suit;
            held++;
            r.ok = 1'b1;
          end
        end
        OP_POP: begin
          if (held > 0) begin
            held--;
            r.out_rank = ranks[held];
            r.out_suit = suits[held];
            r.ok = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (held > 0 && int'(pos) <= held) begin
            r.out_rank = ranks[(int'(pos) == held) ? held - 1 : int'(pos)];
            r.out_suit = suits[(int'(pos) == held) ? held - 1 : int'(pos)];
            // close the gap: only valid entries above the hole move down
            for (i = int'(pos); i + 1 < held; i++) begin
              ranks[i] = ranks[i + 1];
              suits[i] = suits[i + 1];
            end
            held--;
            r.ok = 1'b1;
          end
        end
        OP_FIND: begin
          for (i = 0; i < held; i++) begin
            if (!r.ok && ranks[i] == rank) begin
              r.ok = 1'b1;
              r.found_index = POS_W'(i);
            end
          end
        end
        OP_CLEAR: begin
          held = 0;
          r.ok = 1'b1;
        end
        default: ;
      endcase
      r.entry_count = POS_W'(held);
      due_results.push_back(r);
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_result(card_result_t got);
      card_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result %h with nothing pending", got));
      end else begin
        want = due_results.pop_front();
        if (got.ok !== want.ok)
          report($sformatf("ok got %b want %b", got.ok, want.ok));
        if (got.out_rank !== want.out_rank)
          report($sformatf("out_rank got %0d want %0d", got.out_rank, want.out_rank));
        if (got.out_suit !== want.out_suit)
          report($sformatf("out_suit got %0d want %0d", got.out_suit, want.out_suit));
        if (got.found_index !== want.found_index)
          report($sformatf("found_index got %0d want %0d",
                           got.found_index, want.found_index));
        if (got.entry_count !== want.entry_count)
          report($sformatf("entry_count got %0d want %0d",
                           got.entry_count, want.entry_count));
      end
    endtask
  endclass

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;   // op, card_rank, card_suit, position; pad
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;   // ok, out_rank, out_suit, found_index, entry_count; pad

  bit idle_on   = 1'b1;
  int hold_reqs = 0;

  card_stack_tracker stack_model = new();

  bounded_card_stack_engine_core #(.DEPTH(DEPTH)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Check every result transfer against the oldest pending one
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      stack_model.check_result(card_result_t'(m_axis_tdata[RES_W-1:0]));
  end

  // Receiver: random stall bursts, plus a long hold when the sender asks
  initial begin : receiver
    int stall_left;
    int hold_left;
    int holds_seen;
    stall_left = 0;
    hold_left  = 0;
    holds_seen = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_seen) begin
        holds_seen = hold_reqs;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one operation, wait for its transfer, then record it in the model
  task automatic send_card_op(input logic [OP_W-1:0] op, input logic [RANK_W-1:0] rank,
                              input logic [SUIT_W-1:0] suit, input logic [POS_W-1:0] pos);
    int gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({pos, suit, rank, op});
    do @(posedge clk_i); while (!s_axis_tready);
    stack_model.apply_op(op, rank, suit, pos);
  endtask

  initial begin : stimulus
    int blk;
    int n;
    int pick;
    bit grow;
    logic [OP_W-1:0]   op;
    logic [RANK_W-1:0] rank;
    logic [SUIT_W-1:0] suit;
    logic [POS_W-1:0]  pos;

    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-stack failures, field extremes, compaction, bad codes
    send_card_op(OP_POP,    4'd0,  2'd0, 6'd0);
    send_card_op(OP_REMOVE, 4'd0,  2'd0, 6'd0);
    send_card_op(OP_FIND,   4'd1,  2'd0, 6'd0);
    send_card_op(OP_PUSH,   4'd0,  2'd0, 6'd0);
    send_card_op(OP_PUSH,   4'd15, 2'd3, 6'd63);
    send_card_op(OP_PUSH,   4'd1,  2'd1, 6'd0);
    send_card_op(OP_PUSH,   4'd13, 2'd2, 6'd0);
    send_card_op(OP_PUSH,   4'd7,  2'd1, 6'd0);
    send_card_op(OP_FIND,   4'd15, 2'd0, 6'd0);
    send_card_op(OP_FIND,   4'd9,  2'd3, 6'd63);
    send_card_op(OP_REMOVE, 4'd0,  2'd0, 6'd6);
    send_card_op(OP_REMOVE, 4'd0,  2'd0, 6'd63);
    send_card_op(OP_REMOVE, 4'd0,  2'd0, 6'd5);
    send_card_op(OP_REMOVE, 4'd0,  2'd0, 6'd1);
    send_card_op(OP_FIND,   4'd13, 2'd0, 6'd0);
    send_card_op(OP_POP,    4'd0,  2'd0, 6'd0);
    send_card_op(OP_BAD_LO, 4'd15, 2'd3, 6'd63);
    send_card_op(OP_BAD_MID, 4'd1, 2'd1, 6'd1);
    send_card_op(OP_BAD_HI, 4'd0,  2'd0, 6'd0);
    send_card_op(OP_CLEAR,  4'd0,  2'd0, 6'd0);
    send_card_op(OP_POP,    4'd0,  2'd0, 6'd0);
    send_card_op(OP_PUSH,   4'd10, 2'd2, 6'd42);
    send_card_op(OP_FIND,   4'd10, 2'd0, 6'd0);
    send_card_op(OP_REMOVE, 4'd0,  2'd0, 6'd0);

    // Random: alternate growing and shrinking phases of random content
    for (blk = 0; blk < RAND_BLOCKS; blk++) begin
      grow = (blk % 2 == 0);
      if (blk == RAND_BLOCKS - 1)
        idle_on = 1'b0;

      if (blk == 2) begin
        // fill to the top, then hammer the full stack
        while (stack_model.held < DEPTH)
          send_card_op(OP_PUSH, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                       6'($urandom_range(0, 63)));
        repeat (3)
          send_card_op(OP_PUSH, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                       6'($urandom_range(0, 63)));
        send_card_op(OP_FIND, stack_model.ranks[DEPTH-1], 2'd0, 6'd0);
        send_card_op(OP_REMOVE, 4'd0, 2'd0, 6'd0);
      end
      if (blk == 4)
        hold_reqs <= hold_reqs + 1;   // sender keeps offering meanwhile
      if (blk == 6) begin
        // let the block drain completely before going on
        s_axis_tvalid <= 1'b0;
        while (stack_model.due_results.size() != 0) @(posedge clk_i);
      end

      for (n = 0; n < BLOCK_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        rank = 4'($urandom_range(0, 15));
        suit = 2'($urandom_range(0, 3));
        pos  = 6'($urandom_range(0, 63));
        if (pick < (grow ? 60 : 25)) begin
          op = OP_PUSH;
        end else if (pick < (grow ? 70 : 55)) begin
          op = OP_POP;
        end else if (pick < (grow ? 85 : 80)) begin
          op = OP_REMOVE;
          if ($urandom_range(0, 4) != 0)
            pos = 6'($urandom_range(0, stack_model.held));
        end else if (pick < 95) begin
          op = OP_FIND;
          if (stack_model.held > 0 && $urandom_range(0, 9) < 7)
            rank = stack_model.ranks[$urandom_range(0, stack_model.held - 1)];
        end else if (pick < 96) begin
          op = OP_CLEAR;
        end else begin
          op = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
        end
        send_card_op(op, rank, suit, pos);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (stack_model.due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (stack_model.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
